### rtl/rca_pkg.sv
// Shared constants and types for the reference-counted channel allocator.
package rca_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int KEY_BITS     = 16;

  localparam int IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HW_W    = $clog2(MAX_CHANNELS + 1);
  localparam int COUNT_W = 16;
  localparam int KEY_W   = KEY_BITS;

  // Port field widths
  localparam int DEST_KEY_W = 16;
  localparam int CHANNEL_W  = 6;
  localparam int STATUS_W   = 3;
  localparam int BUS_SIZE_W = 7;

  // Request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_REUSED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HELD       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_COUNT_FULL = 3'd6;

  // Cell update operations
  localparam logic [1:0] OP_NEW = 2'd0;
  localparam logic [1:0] OP_INC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Search token that walks down the row of cells
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             hit_full;
    logic             hit_one;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
  } rca_tok_t;

  // Update broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } rca_wr_t;

endpackage

### rtl/rca_cell.sv
// One channel entry: owner key, reference count and one search token stage.
module rca_cell import rca_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  rca_tok_t         tok_in,
  input  rca_wr_t          wr,
  output rca_tok_t         tok_out
);

  logic [KEY_W-1:0]   key_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  rca_tok_t           tok_r;
  rca_tok_t           tok_nxt;
  logic               live;
  logic               sel;

  assign live = (cnt_r != '0);
  assign sel  = wr.en && (wr.idx == cell_idx);

  // Mark the token with the first live owner and the first free entry
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid) begin
      if (!tok_in.hit && live && (key_r == tok_in.key)) begin
        tok_nxt.hit      = 1'b1;
        tok_nxt.hit_idx  = cell_idx;
        tok_nxt.hit_full = (cnt_r == COUNT_MAX);
        tok_nxt.hit_one  = (cnt_r == COUNT_W'(1));
      end
      if (!tok_in.free_hit && !live) begin
        tok_nxt.free_hit = 1'b1;
        tok_nxt.free_idx = cell_idx;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (sel) begin
      case (wr.op)
        OP_NEW:  cnt_nxt = COUNT_W'(1);
        OP_INC:  cnt_nxt = cnt_r + COUNT_W'(1);
        OP_DEC:  cnt_nxt = cnt_r - COUNT_W'(1);
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tok_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && (wr.op == OP_NEW)) begin
      key_r <= wr.key;
    end
  end

  assign tok_out = tok_r;

endmodule

### rtl/refcounted_channel_allocator.sv
// Top level of the reference-counted channel allocator.
//
// Input channel (in_*): one request per transfer. in_tuser is the kind
// (allocate or release), in_tdata the destination key. Result channel
// (out_*): exactly one result per request, in request order.
// A request launches a search token into a row of MAX_CHANNELS cells; the
// token advances one cell per cycle, recording the first live entry owned
// by the key and the first free entry. When it leaves the last cell the
// decision is made and at most one update is broadcast to all cells,
// addressed to the chosen entry. The walk of the token down the cell row
// sets the request rate; one request is in flight, and no new request is
// taken until the last one is finished.
// in_tready is high while no request is in flight, even if a finished
// result still waits in the output register.
// Reset clears every reference count and the bus size; owner keys are
// only read for live entries and need no reset.
// When the receiver stalls, hold the result in the output register; a
// finished search waits for the register to drain before it updates state.
module refcounted_channel_allocator import rca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] dest_key
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] channel, [12:6] bus_size, [13] bus_grew, zero pad
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  rca_tok_t              launch_r, launch_nxt;
  rca_tok_t              hold_r;
  rca_tok_t              chain [MAX_CHANNELS+1];
  rca_wr_t               wr;
  logic [HW_W-1:0]       hw_r, hw_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHANNEL_W-1:0]  res_ch_r, res_ch_nxt;
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic                  res_grew_r, res_grew_nxt;
  logic                  in_xfer;
  logic                  out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Launch register feeds the first cell
  always_comb begin
    launch_nxt       = '0;
    launch_nxt.valid = in_xfer;
    launch_nxt.kind  = in_tuser[0];
    launch_nxt.key   = KEY_W'(in_tdata);
  end

  assign chain[0] = launch_r;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    rca_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .tok_in   (chain[i]),
      .wr       (wr),
      .tok_out  (chain[i+1])
    );
  end

  // Decide the result once the token has passed every cell
  always_comb begin
    state_nxt     = state_r;
    hw_nxt        = hw_r;
    out_valid_nxt = out_valid_r;
    res_ch_nxt    = res_ch_r;
    res_st_nxt    = res_st_r;
    res_grew_nxt  = res_grew_r;
    wr            = '0;
    wr.key        = hold_r.key;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain[MAX_CHANNELS].valid) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_ch_nxt    = '0;
          res_grew_nxt  = 1'b0;
          if (hold_r.kind == KIND_ALLOC) begin
            if (hold_r.hit) begin
              if (hold_r.hit_full) begin
                res_st_nxt = ST_COUNT_FULL;
              end else begin
                res_st_nxt = ST_REUSED;
                res_ch_nxt = CHANNEL_W'(hold_r.hit_idx);
                wr.en      = 1'b1;
                wr.op      = OP_INC;
                wr.idx     = hold_r.hit_idx;
              end
            end else if (hold_r.free_hit) begin
              res_st_nxt = ST_NEW;
              res_ch_nxt = CHANNEL_W'(hold_r.free_idx);
              wr.en      = 1'b1;
              wr.op      = OP_NEW;
              wr.idx     = hold_r.free_idx;
              if (HW_W'(hold_r.free_idx) >= hw_r) begin
                hw_nxt       = HW_W'(hold_r.free_idx) + HW_W'(1);
                res_grew_nxt = 1'b1;
              end
            end else begin
              res_st_nxt = ST_NO_FREE;
            end
          end else begin
            if (hold_r.hit) begin
              res_st_nxt = hold_r.hit_one ? ST_FREED : ST_HELD;
              res_ch_nxt = CHANNEL_W'(hold_r.hit_idx);
              wr.en      = 1'b1;
              wr.op      = OP_DEC;
              wr.idx     = hold_r.hit_idx;
            end else begin
              res_st_nxt = ST_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and the captured token
  always_ff @(posedge clk) begin
    res_ch_r   <= res_ch_nxt;
    res_st_r   <= res_st_nxt;
    res_grew_r <= res_grew_nxt;
    if (state_r == S_SCAN && chain[MAX_CHANNELS].valid) begin
      hold_r <= chain[MAX_CHANNELS];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_st_r;
  assign out_tdata  = {2'b00, res_grew_r, BUS_SIZE_W'(hw_r), res_ch_r};

endmodule
